// ===== rtl/core/sbt_pkg.sv =====
package sbt_pkg;

  localparam int unsigned MAX_TICKS_DEF  = 16;
  localparam int unsigned MAX_FRAMES_DEF = 4096;

  localparam int unsigned SR_W     = 18;
  localparam int unsigned TEMPO_W  = 17;
  localparam int unsigned SWING_W  = 16;
  localparam int unsigned NF_W     = 13;
  localparam int unsigned OFF_W    = 12;
  localparam int unsigned BEAT_W   = 32;
  localparam int unsigned POS_W    = 64;
  localparam int unsigned FRAC_W   = 16;
  localparam int unsigned DVD_W    = 48;
  localparam int unsigned DVD_SH   = 24;
  localparam int unsigned SPB_W    = 36;
  localparam int unsigned FAC_W    = 17;
  localparam int unsigned IDX_W    = 8;
  localparam int unsigned CFG_W    = 18;
  localparam int unsigned IN_TD_W  = 16;
  localparam int unsigned OUT_TD_W = 48;

  localparam logic [IDX_W-1:0] REG_SAMPLE_RATE = 8'd0;
  localparam logic [IDX_W-1:0] REG_TEMPO       = 8'd1;
  localparam logic [IDX_W-1:0] REG_DOUBLE      = 8'd2;
  localparam logic [IDX_W-1:0] REG_SWING       = 8'd3;

  localparam logic [SR_W-1:0]    SR_RESET    = 18'd48000;
  localparam logic [SR_W-1:0]    SR_MIN      = 18'd1;
  localparam logic [SR_W-1:0]    SR_MAX      = 18'd192000;
  localparam logic [TEMPO_W-1:0] TEMPO_RESET = 17'd30720;
  localparam logic [TEMPO_W-1:0] TEMPO_MIN   = 17'd5120;
  localparam logic [TEMPO_W-1:0] TEMPO_MAX   = 17'd76800;
  localparam logic [SWING_W-1:0] SWING_MAX   = 16'd32768;
  localparam logic [FAC_W-1:0]   FAC_UNITY   = 17'd65536;

  localparam logic [0:0] OP_ADVANCE = 1'b0;
  localparam logic [0:0] OP_RESTART = 1'b1;

  typedef struct packed {
    logic load;
    logic restart;
    logic mul_even;
    logic mul_odd;
    logic test;
    logic step;
    logic finish;
  } sbt_cmd_t;

  typedef struct packed {
    logic op_restart;
    logic n_zero;
    logic div_done;
    logic hit;
    logic pend_valid;
    logic out_free;
  } sbt_sts_t;

endpackage

// ===== rtl/core/swing_beat_tick_scheduler.sv =====
// channel | dir | handshake              | payload
// in      | in  | in_tvalid / in_tready  | in_tdata: num_frames[12:0]; in_tuser: op
// out     | out | out_tvalid / out_tready| out_tdata: frame_offset, beat_number; out_tlast
// cfg     | in  | cfg_valid / cfg_ready  | cfg_index register, cfg_data value
//
// An advance item runs the bit-serial beat interval divide, which dominates, then two swing
// multiplies and a test and step per tick (ticks <= MAX_TICKS), plus output stalls. Restart
// and empty buffers finish in idle. Each pending tick holds the sequencer until the output
// register frees; the last tick of a buffer may sit there while the next item is accepted.
// rst_n is synchronous: registers return to defaults, position and beat count clear.
module swing_beat_tick_scheduler #(
  parameter int unsigned MAX_TICKS  = sbt_pkg::MAX_TICKS_DEF,
  parameter int unsigned MAX_FRAMES = sbt_pkg::MAX_FRAMES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_tvalid,
  output logic                          in_tready,
  input  logic [sbt_pkg::IN_TD_W-1:0]   in_tdata,   // [12:0] num_frames, [15:13] zero
  input  logic                          in_tuser,   // [0] op
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output logic [sbt_pkg::OUT_TD_W-1:0]  out_tdata,  // [11:0] frame_offset, [43:12] beat_number
  output logic                          out_tlast,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sbt_pkg::IDX_W-1:0]     cfg_index,
  input  logic [sbt_pkg::CFG_W-1:0]     cfg_data
);

  sbt_pkg::sbt_cmd_t             cmd;
  sbt_pkg::sbt_sts_t             sts;
  logic [sbt_pkg::OFF_W-1:0]     off;
  logic [sbt_pkg::BEAT_W-1:0]    beat;

  assign cfg_ready = 1'b1;

  sbt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_rdy   (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  sbt_dp #(
    .MAX_TICKS  (MAX_TICKS),
    .MAX_FRAMES (MAX_FRAMES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .sts       (sts),
    .in_op     (in_tuser),
    .in_frames (in_tdata[sbt_pkg::NF_W-1:0]),
    .cfg_we    (cfg_valid),
    .cfg_idx   (cfg_index),
    .cfg_wdata (cfg_data),
    .out_valid (out_tvalid),
    .out_rdy   (out_tready),
    .out_off   (off),
    .out_beat  (beat),
    .out_last  (out_tlast)
  );

  assign out_tdata = {{(sbt_pkg::OUT_TD_W - sbt_pkg::OFF_W - sbt_pkg::BEAT_W){1'b0}},
                      beat, off};

endmodule

// ===== rtl/core/sbt_div.sv =====
module sbt_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [sbt_pkg::SR_W-1:0]    sample_rate,
  input  logic [sbt_pkg::TEMPO_W-1:0] tempo,
  output logic                        done,
  output logic [sbt_pkg::SPB_W-1:0]   quotient
);

  localparam int unsigned CNT_W = $clog2(sbt_pkg::DVD_W);

  logic                        busy_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [sbt_pkg::DVD_W-1:0]   dq_r;
  logic [sbt_pkg::TEMPO_W-1:0] dvs_r;
  logic [sbt_pkg::TEMPO_W-1:0] rem_r;
  logic [sbt_pkg::TEMPO_W:0]   rem_sh;
  logic                        ge;
  logic [sbt_pkg::TEMPO_W:0]   rem_sub;
  logic [sbt_pkg::DVD_SH-1:0]  sr60;

  assign sr60    = sbt_pkg::DVD_SH'({6'd0, sample_rate} * 24'd60);
  assign rem_sh  = {rem_r, dq_r[sbt_pkg::DVD_W-1]};
  assign ge      = rem_sh >= {1'b0, dvs_r};
  assign rem_sub = rem_sh - {1'b0, dvs_r};

  assign done     = busy_r && (cnt_r == '0);
  assign quotient = dq_r[sbt_pkg::SPB_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CNT_W'(sbt_pkg::DVD_W - 1);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dq_r  <= {sr60, {sbt_pkg::DVD_SH{1'b0}}};
      dvs_r <= tempo;
      rem_r <= '0;
    end else if (busy_r) begin
      dq_r  <= {dq_r[sbt_pkg::DVD_W-2:0], ge};
      rem_r <= ge ? rem_sub[sbt_pkg::TEMPO_W-1:0] : rem_sh[sbt_pkg::TEMPO_W-1:0];
    end
  end

endmodule

// ===== rtl/core/sbt_dp.sv =====
module sbt_dp #(
  parameter int unsigned MAX_TICKS  = sbt_pkg::MAX_TICKS_DEF,
  parameter int unsigned MAX_FRAMES = sbt_pkg::MAX_FRAMES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  sbt_pkg::sbt_cmd_t              cmd,
  output sbt_pkg::sbt_sts_t              sts,
  input  logic                           in_op,
  input  logic [sbt_pkg::NF_W-1:0]       in_frames,
  input  logic                           cfg_we,
  input  logic [sbt_pkg::IDX_W-1:0]      cfg_idx,
  input  logic [sbt_pkg::CFG_W-1:0]      cfg_wdata,
  output logic                           out_valid,
  input  logic                           out_rdy,
  output logic [sbt_pkg::OFF_W-1:0]      out_off,
  output logic [sbt_pkg::BEAT_W-1:0]     out_beat,
  output logic                           out_last
);

  localparam int unsigned CNT_W = $clog2(MAX_TICKS + 1);
  localparam int unsigned MF_W  = $clog2(MAX_FRAMES + 1);
  localparam int unsigned CMP_W = (MF_W > sbt_pkg::NF_W) ? MF_W : sbt_pkg::NF_W;
  localparam int unsigned PRD_W = sbt_pkg::SPB_W + sbt_pkg::FAC_W;

  logic [sbt_pkg::SR_W-1:0]    sr_r;
  logic [sbt_pkg::TEMPO_W-1:0] tempo_r;
  logic                        mode_r;
  logic [sbt_pkg::SWING_W-1:0] swing_r;

  logic [sbt_pkg::POS_W-1:0]   pos_r;
  logic [sbt_pkg::POS_W-1:0]   next_r;
  logic [sbt_pkg::BEAT_W-1:0]  beat_r;
  logic [sbt_pkg::NF_W-1:0]    n_r;
  logic [sbt_pkg::POS_W-1:0]   end_r;
  logic [CNT_W-1:0]            cnt_r;
  logic [sbt_pkg::SPB_W-1:0]   iv_even_r;
  logic [sbt_pkg::SPB_W-1:0]   iv_odd_r;
  logic                        hit_r;
  logic [sbt_pkg::NF_W-1:0]    off_r;
  logic                        pend_valid_r;
  logic [sbt_pkg::NF_W-1:0]    pend_off_r;
  logic [sbt_pkg::BEAT_W-1:0]  pend_beat_r;
  logic                        out_valid_r;
  logic [sbt_pkg::OFF_W-1:0]   out_off_r;
  logic [sbt_pkg::BEAT_W-1:0]  out_beat_r;
  logic                        out_last_r;

  logic                        div_done;
  logic [sbt_pkg::SPB_W-1:0]   spb;
  logic [sbt_pkg::NF_W-1:0]    n_clamp;
  logic [sbt_pkg::FAC_W-1:0]   fac;
  logic [PRD_W-1:0]            prod;
  logic [sbt_pkg::SPB_W-1:0]   iv_scaled;
  logic [sbt_pkg::SPB_W-1:0]   iv_sel;
  logic [sbt_pkg::POS_W-1:0]   t64;
  logic [sbt_pkg::POS_W-1:0]   diff;
  logic [sbt_pkg::NF_W-1:0]    nm1;
  logic [sbt_pkg::NF_W-1:0]    off_nxt;
  logic                        hit_nxt;
  logic                        out_free;
  logic                        push;
  logic                        push_last;
  logic [sbt_pkg::SR_W-1:0]    w_sr;
  logic [sbt_pkg::TEMPO_W-1:0] w_tempo;
  logic [sbt_pkg::SWING_W-1:0] w_swing;

  sbt_div u_div (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (cmd.load),
    .sample_rate (sr_r),
    .tempo       (tempo_r),
    .done        (div_done),
    .quotient    (spb)
  );

  // config saturation
  assign w_sr    = cfg_wdata[sbt_pkg::SR_W-1:0];
  assign w_tempo = cfg_wdata[sbt_pkg::TEMPO_W-1:0];
  assign w_swing = cfg_wdata[sbt_pkg::SWING_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sr_r    <= sbt_pkg::SR_RESET;
      tempo_r <= sbt_pkg::TEMPO_RESET;
      mode_r  <= 1'b0;
      swing_r <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        sbt_pkg::REG_SAMPLE_RATE: begin
          if (w_sr < sbt_pkg::SR_MIN) sr_r <= sbt_pkg::SR_MIN;
          else if (w_sr > sbt_pkg::SR_MAX) sr_r <= sbt_pkg::SR_MAX;
          else sr_r <= w_sr;
        end
        sbt_pkg::REG_TEMPO: begin
          if (w_tempo < sbt_pkg::TEMPO_MIN) tempo_r <= sbt_pkg::TEMPO_MIN;
          else if (w_tempo > sbt_pkg::TEMPO_MAX) tempo_r <= sbt_pkg::TEMPO_MAX;
          else tempo_r <= w_tempo;
        end
        sbt_pkg::REG_DOUBLE: mode_r <= cfg_wdata[0];
        sbt_pkg::REG_SWING: begin
          swing_r <= (w_swing > sbt_pkg::SWING_MAX) ? sbt_pkg::SWING_MAX : w_swing;
        end
        default: ;
      endcase
    end
  end

  // buffer length clamp
  always_comb begin
    if (CMP_W'(in_frames) > CMP_W'(MAX_FRAMES)) n_clamp = sbt_pkg::NF_W'(MAX_FRAMES);
    else n_clamp = in_frames;
  end

  // swing intervals
  assign fac       = cmd.mul_even ? (sbt_pkg::FAC_UNITY + sbt_pkg::FAC_W'(swing_r))
                                  : (sbt_pkg::FAC_UNITY - sbt_pkg::FAC_W'(swing_r));
  assign prod      = PRD_W'(spb) * PRD_W'(fac);
  assign iv_scaled = prod[PRD_W-1:sbt_pkg::FAC_W];
  assign iv_sel    = beat_r[0] ? iv_odd_r : iv_even_r;

  always_ff @(posedge clk) begin
    if (cmd.mul_even) iv_even_r <= mode_r ? iv_scaled : spb;
    if (cmd.mul_odd)  iv_odd_r  <= mode_r ? iv_scaled : spb;
  end

  // tick test
  assign t64  = {{sbt_pkg::FRAC_W{1'b0}}, next_r[sbt_pkg::POS_W-1:sbt_pkg::FRAC_W]};
  assign diff = t64 - pos_r;
  assign nm1  = n_r - 1'b1;

  always_comb begin
    hit_nxt = (cnt_r < CNT_W'(MAX_TICKS)) && (t64 < end_r);
    if (t64 < pos_r) off_nxt = '0;
    else if (diff > sbt_pkg::POS_W'(nm1)) off_nxt = nm1;
    else off_nxt = diff[sbt_pkg::NF_W-1:0];
  end

  assign out_free  = !out_valid_r || out_rdy;
  assign push      = (cmd.step && pend_valid_r) || (cmd.finish && pend_valid_r);
  assign push_last = cmd.finish && pend_valid_r;

  always_ff @(posedge clk) begin
    if (cmd.test) begin
      hit_r <= hit_nxt;
      off_r <= off_nxt;
    end
    if (cmd.load) begin
      n_r   <= n_clamp;
      end_r <= pos_r + sbt_pkg::POS_W'(n_clamp);
    end
    if (cmd.step) begin
      pend_off_r  <= off_r;
      pend_beat_r <= beat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      next_r       <= '0;
      beat_r       <= '0;
      cnt_r        <= '0;
      pend_valid_r <= 1'b0;
    end else begin
      if (cmd.restart) begin
        pos_r  <= '0;
        next_r <= '0;
        beat_r <= '0;
      end
      if (cmd.load) begin
        cnt_r        <= '0;
        pend_valid_r <= 1'b0;
      end
      if (cmd.step) begin
        pend_valid_r <= 1'b1;
        cnt_r        <= cnt_r + 1'b1;
        beat_r       <= beat_r + 1'b1;
        next_r       <= next_r + sbt_pkg::POS_W'(iv_sel);
      end
      if (cmd.finish) begin
        pend_valid_r <= 1'b0;
        pos_r        <= end_r;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (push) begin
      out_valid_r <= 1'b1;
    end else if (out_rdy) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      out_off_r  <= pend_off_r[sbt_pkg::OFF_W-1:0];
      out_beat_r <= pend_beat_r;
      out_last_r <= push_last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_off   = out_off_r;
  assign out_beat  = out_beat_r;
  assign out_last  = out_last_r;

  assign sts.op_restart = (in_op == sbt_pkg::OP_RESTART);
  assign sts.n_zero     = (in_frames == '0);
  assign sts.div_done   = div_done;
  assign sts.hit        = hit_r;
  assign sts.pend_valid = pend_valid_r;
  assign sts.out_free   = out_free;

`ifndef SYNTHESIS
  a_push_free: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> out_free) else $error("output overwritten");
  a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
    push_last |=> !pend_valid_r && out_valid_r && out_last_r)
    else $error("final tick not flushed");
  a_step_hit: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> hit_r) else $error("step without hit");
`endif

endmodule

// ===== rtl/core/sbt_ctrl.sv =====
module sbt_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_rdy,
  input  sbt_pkg::sbt_sts_t sts,
  output sbt_pkg::sbt_cmd_t cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIV  = 3'd1;
  localparam logic [2:0] ST_MULE = 3'd2;
  localparam logic [2:0] ST_MULO = 3'd3;
  localparam logic [2:0] ST_TEST = 3'd4;
  localparam logic [2:0] ST_STEP = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  logic [2:0] state_r;
  logic [2:0] state_nxt;
  logic       emit_ok;

  assign emit_ok = !sts.pend_valid || sts.out_free;
  assign in_rdy  = (state_r == ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (sts.op_restart) begin
            cmd.restart = 1'b1;
          end else if (!sts.n_zero) begin
            cmd.load  = 1'b1;
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (sts.div_done) state_nxt = ST_MULE;
      end
      ST_MULE: begin
        cmd.mul_even = 1'b1;
        state_nxt    = ST_MULO;
      end
      ST_MULO: begin
        cmd.mul_odd = 1'b1;
        state_nxt   = ST_TEST;
      end
      ST_TEST: begin
        cmd.test  = 1'b1;
        state_nxt = ST_STEP;
      end
      ST_STEP: begin
        if (!sts.hit) begin
          state_nxt = ST_FIN;
        end else if (emit_ok) begin
          cmd.step  = 1'b1;
          state_nxt = ST_TEST;
        end
      end
      ST_FIN: begin
        if (emit_ok) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

`ifndef SYNTHESIS
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == ST_DIV) else $error("divider done outside wait");
  a_fin_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> in_rdy) else $error("not idle after finish");
  a_load_div: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_DIV) else $error("load did not start divide");
`endif

endmodule
